// ----- rtl/homography_perturbed_points_unit_assert.svh -----
// Assertion helpers shared by the perturbed point unit.
`ifndef HOMOGRAPHY_PERTURBED_POINTS_UNIT_ASSERT_SVH
`define HOMOGRAPHY_PERTURBED_POINTS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hpp_pkg.sv -----
package hpp_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int WARP_FRAC_BITS  = 24;

  // Point scale to 32 fraction bits, and derived internal widths
  localparam int PT_SHIFT = 32 - COORD_FRAC_BITS;
  localparam int PW       = 32 + PT_SHIFT;
  localparam int DLW      = 64 - WARP_FRAC_BITS;
  localparam int VW       = DLW + 1;
  localparam int QW       = ((PW > VW) ? PW : VW) + 1;
  // Quotient bits kept before the final rounding
  localparam int QB       = 33;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic signed [31:0] WARP_ONE = 32'sd1 <<< WARP_FRAC_BITS;
  localparam logic [31:0]        STEP_RST = 32'd429497;
  localparam logic [31:0]        SAT_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_MIN  = 32'h8000_0000;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_C0X  = 3'd0,
    REG_C0Y  = 3'd1,
    REG_C0W  = 3'd2,
    REG_C1X  = 3'd3,
    REG_C1Y  = 3'd4,
    REG_C1W  = 3'd5,
    REG_STEP = 3'd6,
    REG_MODE = 3'd7
  } hpp_reg_e;

  typedef struct packed {
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_w;
  } hpp_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [2:0]         perturb_index;
    logic               last_of_run;
    logic               divide_fault;
  } hpp_out_t;

  typedef logic signed [DLW-1:0] hpp_delta_t;
  typedef logic signed [QW-1:0]  hpp_q_t;

  // Per-column deltas, from the config block
  typedef struct packed {
    hpp_delta_t d0x;
    hpp_delta_t d0y;
    hpp_delta_t d0w;
    hpp_delta_t d1x;
    hpp_delta_t d1y;
    hpp_delta_t d1w;
  } hpp_deltas_t;

  // Queue entry: point tagged with its run mode
  typedef struct packed {
    hpp_in_t pt;
    logic    hess;
  } hpp_qent_t;

  // One perturbed homogeneous point headed for the divider
  typedef struct packed {
    hpp_q_t     qx;
    hpp_q_t     qy;
    hpp_q_t     qw;
    logic [2:0] idx;
    logic       last;
  } hpp_vec_t;

  // Warp entry times step, full precision
  function automatic logic signed [63:0] hpp_mul(logic signed [31:0] c, logic [31:0] e);
    logic signed [64:0] full;
    full = c * $signed({1'b0, e});
    return full[63:0];
  endfunction

endpackage

// ----- rtl/hpp_cfg.sv -----
module hpp_cfg import hpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hpp_deltas_t deltas,
  output logic        hess
);

  logic signed [31:0] c_r [6];
  logic [31:0]        step_r;
  logic               hess_r;
  logic signed [63:0] prod_r [6];
  hpp_delta_t         d [6];
  logic               wr_en;
  hpp_reg_e           ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = hpp_reg_e'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r[0] <= WARP_ONE;
      c_r[1] <= '0;
      c_r[2] <= '0;
      c_r[3] <= '0;
      c_r[4] <= WARP_ONE;
      c_r[5] <= '0;
      step_r <= STEP_RST;
      hess_r <= 1'b0;
    end else if (wr_en) begin
      case (ridx)
        REG_C0X:  c_r[0] <= pwdata;
        REG_C0Y:  c_r[1] <= pwdata;
        REG_C0W:  c_r[2] <= pwdata;
        REG_C1X:  c_r[3] <= pwdata;
        REG_C1Y:  c_r[4] <= pwdata;
        REG_C1W:  c_r[5] <= pwdata;
        REG_STEP: step_r <= pwdata;
        REG_MODE: hess_r <= pwdata[0];
        default:  ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (ridx)
      REG_C0X:  prdata = c_r[0];
      REG_C0Y:  prdata = c_r[1];
      REG_C0W:  prdata = c_r[2];
      REG_C1X:  prdata = c_r[3];
      REG_C1Y:  prdata = c_r[4];
      REG_C1W:  prdata = c_r[5];
      REG_STEP: prdata = step_r;
      REG_MODE: prdata = {31'd0, hess_r};
      default:  prdata = '0;
    endcase
  end

  // Column times step, registered; updates in the cycle after a register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r[0] <= hpp_mul(WARP_ONE, STEP_RST);
      prod_r[1] <= '0;
      prod_r[2] <= '0;
      prod_r[3] <= '0;
      prod_r[4] <= hpp_mul(WARP_ONE, STEP_RST);
      prod_r[5] <= '0;
    end else begin
      for (int i = 0; i < 6; i++) begin
        prod_r[i] <= hpp_mul(c_r[i], step_r);
      end
    end
  end

  // Round half up and drop the warp fraction
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      d[i] = DLW'((prod_r[i] + (64'sd1 <<< (WARP_FRAC_BITS - 1))) >>> WARP_FRAC_BITS);
    end
  end

  assign deltas = '{d0x: d[0], d0y: d[1], d0w: d[2], d1x: d[3], d1y: d[4], d1w: d[5]};
  assign hess   = hess_r;

endmodule

// ----- rtl/hpp_front.sv -----
`include "homography_perturbed_points_unit_assert.svh"

module hpp_front import hpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hpp_in_t   in_data,
  input  logic      hess,
  output logic      head_valid,
  output hpp_qent_t head,
  input  logic      pop
);

  hpp_qent_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r;
  logic [FIFO_AW-1:0]   rp_r;
  logic [FIFO_AW:0]     cnt_r;
  logic                 push;
  logic                 do_pop;

  assign in_stall   = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (cnt_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem_r[rp_r];

  // Queue storage; each item tagged with the run mode at accept
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{pt: in_data, hess: hess};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(do_pop);
    end
  end

  `HPP_ASSERT_NEXT(a_cnt_track, 1'b1, cnt_r == $past(cnt_r) + (FIFO_AW + 1)'($past(push)) - (FIFO_AW + 1)'($past(do_pop)), "queue count mismatch")
  `HPP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH), "queue overfilled")

endmodule

// ----- rtl/hpp_expand.sv -----
`include "homography_perturbed_points_unit_assert.svh"

module hpp_expand import hpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  hpp_qent_t   head,
  input  hpp_deltas_t deltas,
  input  logic        adv,
  output logic        pop,
  output logic        s0_valid,
  output hpp_vec_t    s0
);

  typedef logic signed [VW-1:0] vcomp_t;

  logic [2:0] k_r;
  logic [2:0] last_k;
  logic       fire;
  logic       s0_valid_r;
  hpp_vec_t   s0_r;
  hpp_vec_t   s0_nxt;
  vcomp_t     vx, vy, vw;
  hpp_q_t     px, py, pw;

  // Vector component by run position
  function automatic vcomp_t pick(logic h, logic [1:0] sel, hpp_delta_t a, hpp_delta_t b);
    vcomp_t ea;
    vcomp_t eb;
    vcomp_t r;
    ea = VW'(a);
    eb = VW'(b);
    if (h) begin
      case (sel)
        2'd0:    r = ea <<< 1;
        2'd1:    r = eb <<< 1;
        2'd2:    r = ea + eb;
        default: r = ea - eb;
      endcase
    end else begin
      r = sel[0] ? eb : ea;
    end
    return r;
  endfunction

  assign last_k   = head.hess ? 3'd7 : 3'd3;
  assign fire     = head_valid && adv;
  assign pop      = fire && (k_r == last_k);
  assign s0_valid = s0_valid_r;
  assign s0       = s0_r;

  // Perturbed point for the current position
  always_comb begin
    px = hpp_q_t'(head.pt.pt_x) <<< PT_SHIFT;
    py = hpp_q_t'(head.pt.pt_y) <<< PT_SHIFT;
    pw = hpp_q_t'(head.pt.pt_w) <<< PT_SHIFT;
    vx = pick(head.hess, k_r[2:1], deltas.d0x, deltas.d1x);
    vy = pick(head.hess, k_r[2:1], deltas.d0y, deltas.d1y);
    vw = pick(head.hess, k_r[2:1], deltas.d0w, deltas.d1w);
    s0_nxt.qx   = k_r[0] ? px - hpp_q_t'(vx) : px + hpp_q_t'(vx);
    s0_nxt.qy   = k_r[0] ? py - hpp_q_t'(vy) : py + hpp_q_t'(vy);
    s0_nxt.qw   = k_r[0] ? pw - hpp_q_t'(vw) : pw + hpp_q_t'(vw);
    s0_nxt.idx  = k_r;
    s0_nxt.last = (k_r == last_k);
  end

  // Run position and stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      s0_valid_r <= 1'b0;
    end else begin
      if (adv) s0_valid_r <= fire;
      if (fire) k_r <= pop ? 3'd0 : k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) s0_r <= s0_nxt;
  end

  `HPP_ASSERT_NEXT(a_run_wrap, pop, k_r == 3'd0, "run position did not wrap")
  `HPP_ASSERT_NOW(a_grad_range, head_valid && !head.hess, k_r[2] == 1'b0, "gradient run too long")

endmodule

// ----- rtl/hpp_div.sv -----
module hpp_div import hpp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s0_valid,
  input  hpp_vec_t s0,
  output logic     adv,
  output logic     out_valid,
  input  logic     out_stall,
  output hpp_out_t out_data
);

  typedef struct packed {
    logic [QW-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
    logic          neg;
    logic          nneg;
    logic          nz;
    logic          sat;
  } lane_t;

  typedef struct packed {
    lane_t         x;
    lane_t         y;
    logic [QW-1:0] den;
    logic          fault;
    logic [2:0]    idx;
    logic          last;
  } stage_t;

  logic     vld_r [QB + 1];
  stage_t   st_r  [QB + 1];
  stage_t   st0_nxt;
  logic     out_valid_r;
  hpp_out_t out_r;
  hpp_out_t out_nxt;
  logic     wneg;
  logic [QW-1:0] wmag;

  function automatic logic [QW-1:0] mag(hpp_q_t v);
    return v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  // Magnitudes, signs and the overflow precheck
  function automatic lane_t lane_setup(hpp_q_t n, logic dneg, logic [QW-1:0] dmag);
    lane_t         l;
    logic [QW-1:0] m;
    m      = mag(n);
    l.nneg = n[QW-1];
    l.nz   = (n != '0);
    l.neg  = n[QW-1] ^ dneg;
    l.sat  = (m >> PT_SHIFT) >= dmag;
    l.rem  = m >> PT_SHIFT;
    l.low  = QB'(m << (COORD_FRAC_BITS + 1));
    l.quo  = '0;
    return l;
  endfunction

  // One restoring division step
  function automatic lane_t lane_step(lane_t l, logic [QW-1:0] dv);
    lane_t      r;
    logic [QW:0] t;
    logic        ge;
    r  = l;
    t  = {l.rem, l.low[QB-1]};
    ge = t >= {1'b0, dv};
    r.rem = ge ? QW'(t - {1'b0, dv}) : QW'(t);
    r.quo = {l.quo[QB-2:0], ge};
    r.low = {l.low[QB-2:0], 1'b0};
    return r;
  endfunction

  // Round half away from zero and saturate
  function automatic logic [31:0] lane_result(lane_t l, logic fault);
    logic [QB:0]   qp1;
    logic [QB-1:0] qr;
    logic          big;
    logic [31:0]   r;
    qp1 = {1'b0, l.quo} + (QB + 1)'(1);
    qr  = qp1[QB:1];
    big = (qr[QB-1:31] != '0);
    if (fault) begin
      r = !l.nz ? 32'd0 : (l.nneg ? SAT_MIN : SAT_MAX);
    end else if (l.sat || big) begin
      r = l.neg ? SAT_MIN : SAT_MAX;
    end else begin
      r = l.neg ? 32'(-qr[31:0]) : qr[31:0];
    end
    return r;
  endfunction

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Setup stage
  always_comb begin
    wneg          = s0.qw[QW-1];
    wmag          = mag(s0.qw);
    st0_nxt.x     = lane_setup(s0.qx, wneg, wmag);
    st0_nxt.y     = lane_setup(s0.qy, wneg, wmag);
    st0_nxt.den   = wmag;
    st0_nxt.fault = (s0.qw == '0);
    st0_nxt.idx   = s0.idx;
    st0_nxt.last  = s0.last;
  end

  // Valid bits along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= s0_valid;
      for (int i = 1; i <= QB; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[QB];
    end
  end

  // Payload: setup then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s].x     <= lane_step(st_r[s-1].x, st_r[s-1].den);
        st_r[s].y     <= lane_step(st_r[s-1].y, st_r[s-1].den);
        st_r[s].den   <= st_r[s-1].den;
        st_r[s].fault <= st_r[s-1].fault;
        st_r[s].idx   <= st_r[s-1].idx;
        st_r[s].last  <= st_r[s-1].last;
      end
    end
  end

  // Output register
  always_comb begin
    out_nxt.out_x         = lane_result(st_r[QB].x, st_r[QB].fault);
    out_nxt.out_y         = lane_result(st_r[QB].y, st_r[QB].fault);
    out_nxt.perturb_index = st_r[QB].idx;
    out_nxt.last_of_run   = st_r[QB].last;
    out_nxt.divide_fault  = st_r[QB].fault;
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

endmodule

// ----- rtl/homography_perturbed_points_unit.sv -----
// Each accepted item yields a run of results, one result per cycle while out_stall is low:
// four results in gradient mode and eight in Hessian mode, all through the single result port
// fed from a 33-stage restoring divider pipe (x and y lanes).
// A 4-entry queue lets the input side run ahead while results are stalled.
// Reset (rst_n, synchronous, low): empties the queue and pipe, loads register defaults.
module homography_perturbed_points_unit import hpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  hpp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output hpp_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hpp_deltas_t deltas;
  logic        hess;
  logic        head_valid;
  hpp_qent_t   head;
  logic        pop;
  logic        adv;
  logic        s0_valid;
  hpp_vec_t    s0;

  // Registers and column deltas
  hpp_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .deltas, .hess
  );

  // Accept and queue
  hpp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .hess,
    .head_valid, .head, .pop
  );

  // Run sequencing and perturbation
  hpp_expand u_expand (
    .clk, .rst_n, .head_valid, .head, .deltas, .adv, .pop, .s0_valid, .s0
  );

  // Dehomogenize and output
  hpp_div u_div (
    .clk, .rst_n, .s0_valid, .s0, .adv, .out_valid, .out_stall, .out_data
  );

endmodule

// ----- tb/sv/tb_homography_perturbed_points_unit.sv -----
`timescale 1ns / 1ps

module tb_homography_perturbed_points_unit;
  import hpp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  hpp_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  hpp_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  homography_perturbed_points_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the warp and step registers
  logic signed [31:0] c0x, c0y, c0w, c1x, c1y, c1w;
  logic [31:0]        eps;
  logic               hess;

  hpp_out_t pending_points[$];
  int       err_count;
  int       hold_cycles;
  int       hold_req;  // long hold asked for by a test
  int       rx_mode;   // 0 random stall, 1 never stall

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #20ms;
    $display("tb_homography_perturbed_points_unit: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // Scaled column entry times eps, rounded half up
  function automatic logic signed [63:0] delta_of(logic signed [31:0] c);
    logic signed [65:0] prod;
    prod = c * $signed({1'b0, eps});
    prod = prod + (66'sd1 <<< (WARP_FRAC_BITS - 1));
    return 64'(prod >>> WARP_FRAC_BITS);
  endfunction

  // Rounded, saturated quotient num * 2^16 / den
  function automatic logic [31:0] quotient(logic signed [66:0] num,
                                           logic signed [66:0] den,
                                           inout logic fault);
    logic [66:0]  n, d;
    logic [100:0] q;
    logic         neg;
    if (den == 0) begin
      fault = 1'b1;
      if (num > 0) return SAT_MAX;
      if (num < 0) return SAT_MIN;
      return 32'd0;
    end
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (({34'd0, n} << (COORD_FRAC_BITS + 1)) / {34'd0, d} + 1) >> 1;
    if (neg) return (q >= 101'h80000000) ? SAT_MIN : 32'(-q);
    return (q > 101'h7FFFFFFF) ? SAT_MAX : q[31:0];
  endfunction

  task automatic predict_points(input hpp_in_t pt);
    logic signed [66:0] p[3], d0[3], d1[3], v[4][3], q[3];
    logic signed [31:0] c0[3], c1[3];
    hpp_out_t r;
    int nres;
    logic f;
    c0 = '{c0x, c0y, c0w};
    c1 = '{c1x, c1y, c1w};
    p[0] = 67'(pt.pt_x) <<< PT_SHIFT;
    p[1] = 67'(pt.pt_y) <<< PT_SHIFT;
    p[2] = 67'(pt.pt_w) <<< PT_SHIFT;
    for (int j = 0; j < 3; j++) begin
      d0[j] = delta_of(c0[j]);
      d1[j] = delta_of(c1[j]);
      if (hess) begin
        v[0][j] = 2 * d0[j]; v[1][j] = 2 * d1[j];
        v[2][j] = d0[j] + d1[j]; v[3][j] = d0[j] - d1[j];
      end else begin
        v[0][j] = d0[j]; v[1][j] = d1[j]; v[2][j] = 0; v[3][j] = 0;
      end
    end
    nres = hess ? 8 : 4;
    for (int k = 0; k < nres; k++) begin
      for (int j = 0; j < 3; j++)
        q[j] = (k & 1) ? p[j] - v[k >> 1][j] : p[j] + v[k >> 1][j];
      f = 1'b0;
      r.out_x = quotient(q[0], q[2], f);
      r.out_y = quotient(q[1], q[2], f);
      r.perturb_index = 3'(k);
      r.last_of_run = (k == nres - 1);
      r.divide_fault = f;
      pending_points.push_back(r);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result", out_data.out_x, 32'd0);
      end else begin
        hpp_out_t e;
        e = pending_points.pop_front();
        if (out_data.out_x !== e.out_x) report_mismatch("out_x", out_data.out_x, e.out_x);
        if (out_data.out_y !== e.out_y) report_mismatch("out_y", out_data.out_y, e.out_y);
        if (out_data.perturb_index !== e.perturb_index)
          report_mismatch("perturb_index", 32'(out_data.perturb_index),
                          32'(e.perturb_index));
        if (out_data.last_of_run !== e.last_of_run)
          report_mismatch("last_of_run", 32'(out_data.last_of_run), 32'(e.last_of_run));
        if (out_data.divide_fault !== e.divide_fault)
          report_mismatch("divide_fault", 32'(out_data.divide_fault),
                          32'(e.divide_fault));
      end
    end
  end

  // Receiver stall, with long holds counted here
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cycles <= hold_req;
      hold_req = 0;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (rx_mode == 1) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      hold_cycles <= $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  task automatic cfg_write(input hpp_reg_e idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_C0X:  c0x = val;
      REG_C0Y:  c0y = val;
      REG_C0W:  c0w = val;
      REG_C1X:  c1x = val;
      REG_C1Y:  c1y = val;
      REG_C1W:  c1w = val;
      REG_STEP: eps = val;
      REG_MODE: hess = val[0];
      default: ;
    endcase
  endtask

  // Sends one item; optional random gap first. Valid stays up after accept
  // so back to back items need no second drive in one step.
  task automatic send_point(input hpp_in_t pt, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_points(pt);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_points.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 8;
    endcase
  endfunction

  function automatic hpp_in_t rand_point();
    hpp_in_t pt;
    pt.pt_x = rand_coord();
    pt.pt_y = rand_coord();
    case ($urandom_range(0, 5))
      0: pt.pt_w = $urandom;
      1: pt.pt_w = 32'h0;
      2: pt.pt_w = rand_coord();
      default: pt.pt_w = 32'($urandom_range(1, 8)) <<< 16;
    endcase
    return pt;
  endfunction

  task automatic test_reset_defaults();
    hpp_in_t pt;
    pt = '{32'sd0, 32'sd0, 32'sh10000};
    send_point(pt, 0);
    pt = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh10000};
    send_point(pt, 0);
    drain();
  endtask

  // Extremes of points, zero w, and w cancelled by the perturbation
  task automatic test_directed_extremes();
    hpp_in_t pt;
    cfg_write(REG_C0W, 32'h0100_0000);
    cfg_write(REG_C1W, 32'hFF00_0000);
    cfg_write(REG_STEP, 32'hFFFF_FFFF);
    for (int m = 0; m < 2; m++) begin
      cfg_write(REG_MODE, 32'(m));
      pt = '{32'sh10000, -32'sh10000, 32'sh0};        send_point(pt, 0);
      pt = '{32'sh0, 32'sh0, -32'sh10000};            send_point(pt, 0);
      pt = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh1};   send_point(pt, 0);
      pt = '{32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF}; send_point(pt, 0);
      pt = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000}; send_point(pt, 0);
      drain();
    end
    cfg_write(REG_C0X, 32'h8000_0000);
    cfg_write(REG_C0Y, 32'h7FFF_FFFF);
    cfg_write(REG_C1X, 32'h7FFF_FFFF);
    cfg_write(REG_C1Y, 32'h8000_0000);
    cfg_write(REG_STEP, 32'h0);
    pt = '{32'sh12345, 32'sh6789A, 32'sh0};           send_point(pt, 0);
    pt = '{32'sh0, 32'sh0, 32'sh0};                   send_point(pt, 0);
    drain();
  endtask

  task automatic randomize_config(input bit extreme);
    cfg_write(REG_C0X, extreme ? ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000) : $urandom);
    cfg_write(REG_C0Y, $urandom);
    cfg_write(REG_C0W, $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 64)) - 32) <<< 18);
    cfg_write(REG_C1X, $urandom);
    cfg_write(REG_C1Y, extreme ? 32'h80000000 : $urandom);
    cfg_write(REG_C1W, $urandom_range(0, 1) ? $urandom : 32'h0);
    cfg_write(REG_STEP, extreme ? 32'hFFFFFFFF : $urandom);
    cfg_write(REG_MODE, $urandom_range(0, 1));
  endtask

  task automatic test_random_points();
    for (int ph = 0; ph < 8; ph++) begin
      randomize_config(ph == 7);
      rx_mode = (ph == 3);
      for (int i = 0; i < 50; i++) send_point(rand_point(), ph != 3);
      drain();
    end
    rx_mode = 0;
  endtask

  // Long receiver hold while items keep coming, then a paused sender
  task automatic test_backpressure();
    cfg_write(REG_MODE, 1);
    @(posedge clk);
    hold_req = 300;
    for (int i = 0; i < 20; i++) send_point(rand_point(), 0);
    drain();
    for (int i = 0; i < 20; i++) send_point(rand_point(), 1);
    drain();
  endtask

  initial begin
    err_count = 0; hold_cycles = 0; hold_req = 0; rx_mode = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    c0x = WARP_ONE; c0y = 0; c0w = 0; c1x = 0; c1y = WARP_ONE; c1w = 0;
    eps = STEP_RST; hess = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_points();
    test_backpressure();
    drain();
    if (err_count == 0 && pending_points.size() == 0)
      $display("tb_homography_perturbed_points_unit: clean");
    else
      $display("tb_homography_perturbed_points_unit: errors");
    $finish;
  end

endmodule
